>>> design/assert_macros.svh
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ihex_pkg.sv
// Types, microcode table and character helpers of the Intel HEX encoder.
package ihex_pkg;

  typedef enum logic [1:0] {
    REC_SEG,
    REC_DATA,
    REC_EOF
  } rec_e;

  typedef enum logic [1:0] {
    SRC_COLON,
    SRC_HEX,
    SRC_CR,
    SRC_LF
  } src_e;

  typedef enum logic [2:0] {
    SEL_COUNT,
    SEL_ADDR_HI,
    SEL_ADDR_LO,
    SEL_TYPE,
    SEL_DATA,
    SEL_CSUM
  } sel_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_NODATA,
    J_LOOP,
    J_LF_ONLY,
    J_REC_END
  } jmp_e;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    src_e src;
    sel_e sel;
    logic nib_hi;
    logic acc;
    logic clr;
    jmp_e jmp;
    upc_t target;
  } ucode_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] chr;
    logic       last;
  } char_t;

  localparam upc_t UPC_START = 4'd0;
  localparam upc_t UPC_DATA  = 4'd9;
  localparam upc_t UPC_CSUM  = 4'd11;
  localparam upc_t UPC_LF    = 4'd14;

  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_A     = 8'h41;

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;
  localparam logic [7:0] TYPE_SEG  = 8'h04;
  localparam logic [7:0] SEG_COUNT = 8'h02;

  function automatic ucode_t uword(src_e src, sel_e sel, logic nib_hi, logic acc,
                                   logic clr, jmp_e jmp, upc_t target);
    ucode_t w;
    w.src    = src;
    w.sel    = sel;
    w.nib_hi = nib_hi;
    w.acc    = acc;
    w.clr    = clr;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  // One record line: colon, count, address, type, data loop, checksum, line end.
  function automatic ucode_t ucode_rom(upc_t upc);
    ucode_t w;
    case (upc)
      4'd0:    w = uword(SRC_COLON, SEL_COUNT,   1'b0, 1'b0, 1'b1, J_NEXT,    UPC_START);
      4'd1:    w = uword(SRC_HEX,   SEL_COUNT,   1'b1, 1'b0, 1'b0, J_NEXT,    UPC_START);
      4'd2:    w = uword(SRC_HEX,   SEL_COUNT,   1'b0, 1'b1, 1'b0, J_NEXT,    UPC_START);
      4'd3:    w = uword(SRC_HEX,   SEL_ADDR_HI, 1'b1, 1'b0, 1'b0, J_NEXT,    UPC_START);
      4'd4:    w = uword(SRC_HEX,   SEL_ADDR_HI, 1'b0, 1'b1, 1'b0, J_NEXT,    UPC_START);
      4'd5:    w = uword(SRC_HEX,   SEL_ADDR_LO, 1'b1, 1'b0, 1'b0, J_NEXT,    UPC_START);
      4'd6:    w = uword(SRC_HEX,   SEL_ADDR_LO, 1'b0, 1'b1, 1'b0, J_NEXT,    UPC_START);
      4'd7:    w = uword(SRC_HEX,   SEL_TYPE,    1'b1, 1'b0, 1'b0, J_NEXT,    UPC_START);
      4'd8:    w = uword(SRC_HEX,   SEL_TYPE,    1'b0, 1'b1, 1'b0, J_NODATA,  UPC_CSUM);
      4'd9:    w = uword(SRC_HEX,   SEL_DATA,    1'b1, 1'b0, 1'b0, J_NEXT,    UPC_START);
      4'd10:   w = uword(SRC_HEX,   SEL_DATA,    1'b0, 1'b1, 1'b0, J_LOOP,    UPC_DATA);
      4'd11:   w = uword(SRC_HEX,   SEL_CSUM,    1'b1, 1'b0, 1'b0, J_NEXT,    UPC_START);
      4'd12:   w = uword(SRC_HEX,   SEL_CSUM,    1'b0, 1'b0, 1'b0, J_LF_ONLY, UPC_LF);
      4'd13:   w = uword(SRC_CR,    SEL_COUNT,   1'b0, 1'b0, 1'b0, J_NEXT,    UPC_START);
      4'd14:   w = uword(SRC_LF,    SEL_COUNT,   1'b0, 1'b0, 1'b0, J_REC_END, UPC_START);
      default: w = uword(SRC_LF,    SEL_COUNT,   1'b0, 1'b0, 1'b0, J_REC_END, UPC_START);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHR_ZERO + {4'd0, nib};
    end else begin
      c = CHR_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> design/ihex_pack.sv
// Packs the character stream into result transactions of one or two characters.
module ihex_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ihex_pkg::char_t ch_i,
  output logic           take_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     char_first_o,
  output logic [7:0]     char_second_o,
  output logic [1:0]     pair_count_o,
  output logic           run_last_o
);
  import ihex_pkg::*;

  logic       hold_q, hold_d;
  logic [7:0] hold_chr_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] first_q, second_q;
  logic [1:0] count_q;
  logic       last_q;
  logic       out_free;
  logic       load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign take_o   = ch_i.valid && ((!hold_q && !ch_i.last) || out_free);
  assign load     = take_o && (hold_q || ch_i.last);

  always_comb begin
    hold_d      = hold_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      hold_d = !hold_q && !ch_i.last;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && !hold_q) begin
      hold_chr_q <= ch_i.chr;
    end
    if (load) begin
      if (hold_q) begin
        first_q  <= hold_chr_q;
        second_q <= ch_i.chr;
        count_q  <= 2'd2;
      end else begin
        first_q  <= ch_i.chr;
        second_q <= 8'd0;
        count_q  <= 2'd1;
      end
      last_q <= ch_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_first_o  = first_q;
  assign char_second_o = second_q;
  assign pair_count_o  = count_q;
  assign run_last_o    = last_q;

endmodule

>>> design/intel_hex_record_encoder.sv
// Top level of the Intel HEX record encoder.
// A byte that does not close a record is stored in the buffer and produces no
// result. A byte that closes a record (full buffer, end of a 64 KiB segment or
// the final byte) stalls the input while a microcoded sequencer writes the
// record text at one character per cycle while the output does not stall: a
// data record of n bytes is 11 + 2n characters plus the line end, preceded by a
// 15 character extended linear address record plus its line end when the record
// starts at address zero, and followed by the end-of-file record after the final
// byte. Characters leave in pairs; the input is taken again once the last
// character has been handed to the output register, even while that transaction
// still waits.
`include "assert_macros.svh"

module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       image_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_first_o,
  output logic [7:0] char_second_o,
  output logic [1:0] pair_count_o,
  output logic       run_last_o
);
  import ihex_pkg::*;

  localparam int CW = $clog2(RECORD_BYTES + 1);
  localparam int IW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  logic [7:0]    buf_q [RECORD_BYTES];
  logic          busy_q, busy_d;
  logic          last_q, last_d;
  rec_e          kind_q, kind_d;
  upc_t          upc_q, upc_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    sum_q, sum_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [15:0]   addr_q, addr_d;
  logic [15:0]   seg_q, seg_d;
  logic          crlf_q;

  logic          in_accept;
  logic [CW-1:0] fill_new;
  logic [16:0]   addr_sum;
  logic          flush;
  ucode_t        uw;
  logic [7:0]    cnt_byte;
  logic [7:0]    cur_byte;
  logic [7:0]    chr;
  logic          more;
  logic          rec_done_last;
  char_t         ch;
  logic          take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_accept   = in_valid_i && !busy_q;

  assign fill_new = fill_q + 1'b1;
  assign addr_sum = {1'b0, addr_q} + 17'(fill_new);
  assign flush    = image_end_i || (fill_new == CW'(RECORD_BYTES)) || addr_sum[16];

  assign uw = ucode_rom(upc_q);

  always_comb begin
    case (kind_q)
      REC_SEG:  cnt_byte = SEG_COUNT;
      REC_DATA: cnt_byte = 8'(fill_q);
      default:  cnt_byte = 8'd0;
    endcase
  end

  always_comb begin
    case (uw.sel)
      SEL_COUNT:   cur_byte = cnt_byte;
      SEL_ADDR_HI: cur_byte = (kind_q == REC_DATA) ? addr_q[15:8] : 8'd0;
      SEL_ADDR_LO: cur_byte = (kind_q == REC_DATA) ? addr_q[7:0] : 8'd0;
      SEL_TYPE: begin
        case (kind_q)
          REC_SEG:  cur_byte = TYPE_SEG;
          REC_DATA: cur_byte = TYPE_DATA;
          default:  cur_byte = TYPE_EOF;
        endcase
      end
      SEL_DATA: begin
        if (kind_q == REC_SEG) begin
          cur_byte = (idx_q == '0) ? seg_q[15:8] : seg_q[7:0];
        end else begin
          cur_byte = buf_q[idx_q];
        end
      end
      SEL_CSUM: cur_byte = 8'd0 - sum_q;
      default:  cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    case (uw.src)
      SRC_COLON: chr = CHR_COLON;
      SRC_HEX:   chr = hex_char(uw.nib_hi ? cur_byte[7:4] : cur_byte[3:0]);
      SRC_CR:    chr = CHR_CR;
      default:   chr = CHR_LF;
    endcase
  end

  assign more          = (8'(idx_q) + 8'd1) < cnt_byte;
  assign rec_done_last = (kind_q == REC_EOF) || ((kind_q == REC_DATA) && !last_q);

  assign ch.valid = busy_q;
  assign ch.chr   = chr;
  assign ch.last  = (uw.jmp == J_REC_END) && rec_done_last;

  always_comb begin
    busy_d = busy_q;
    last_d = last_q;
    kind_d = kind_q;
    upc_d  = upc_q;
    idx_d  = idx_q;
    sum_d  = sum_q;
    fill_d = fill_q;
    addr_d = addr_q;
    seg_d  = seg_q;
    if (in_accept) begin
      fill_d = fill_new;
      if (flush) begin
        busy_d = 1'b1;
        last_d = image_end_i;
        kind_d = (addr_q == 16'd0) ? REC_SEG : REC_DATA;
        upc_d  = UPC_START;
      end
    end
    if (take) begin
      if (uw.clr) begin
        sum_d = 8'd0;
        idx_d = '0;
      end else if (uw.acc) begin
        sum_d = sum_q + cur_byte;
      end
      case (uw.jmp)
        J_NEXT:   upc_d = upc_q + 1'b1;
        J_NODATA: upc_d = (cnt_byte == 8'd0) ? uw.target : upc_q + 1'b1;
        J_LOOP: begin
          idx_d = idx_q + 1'b1;
          upc_d = more ? uw.target : upc_q + 1'b1;
        end
        J_LF_ONLY: upc_d = crlf_q ? upc_q + 1'b1 : uw.target;
        J_REC_END: begin
          upc_d = UPC_START;
          case (kind_q)
            REC_SEG: begin
              seg_d  = seg_q + 16'd1;
              kind_d = REC_DATA;
            end
            REC_DATA: begin
              addr_d = addr_q + 16'(fill_q);
              fill_d = '0;
              if (last_q) begin
                kind_d = REC_EOF;
              end else begin
                busy_d = 1'b0;
              end
            end
            default: begin
              addr_d = 16'd0;
              seg_d  = 16'd0;
              fill_d = '0;
              busy_d = 1'b0;
            end
          endcase
        end
        default: upc_d = UPC_START;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      last_q <= 1'b0;
      kind_q <= REC_SEG;
      upc_q  <= UPC_START;
      idx_q  <= '0;
      sum_q  <= 8'd0;
      fill_q <= '0;
      addr_q <= 16'd0;
      seg_q  <= 16'd0;
      crlf_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      last_q <= last_d;
      kind_q <= kind_d;
      upc_q  <= upc_d;
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      fill_q <= fill_d;
      addr_q <= addr_d;
      seg_q  <= seg_d;
      if (cfg_valid_i && cfg_ready_o) begin
        crlf_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      buf_q[fill_q[IW-1:0]] <= data_byte_i;
    end
  end

  ihex_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ch_i          (ch),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_first_o  (char_first_o),
    .char_second_o (char_second_o),
    .pair_count_o  (pair_count_o),
    .run_last_o    (run_last_o)
  );

  `ASSERT_ALWAYS(a_fill_below_depth, clk_i, rst_ni, fill_q <= CW'(RECORD_BYTES), "fill overflow")
  `ASSERT_ALWAYS(a_eof_only_last, clk_i, rst_ni, !(busy_q && kind_q == REC_EOF) || last_q, "bad eof")
  `ASSERT_NEXT(a_end_starts_run, clk_i, rst_ni, in_accept && image_end_i, busy_q, "no run")
  `ASSERT_NEXT(a_stall_holds_pc, clk_i, rst_ni, busy_q && !take, $stable(upc_q), "pc moved")

endmodule

>>> tb/tb_intel_hex_record_encoder.sv
// Self-checking testbench for the Intel HEX record encoder: byte stream in, character pairs out.
`timescale 1ns / 1ps

module tb_intel_hex_record_encoder;
  import ihex_pkg::*;

  localparam int unsigned REC_BYTES      = 16;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PRINT_LIMIT    = 50;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } image_byte_t;

  typedef struct {
    logic [7:0] first_chr;
    logic [7:0] second_chr;
    logic [1:0] chars;
    logic       tail;
  } hex_pair_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       image_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] char_first_o;
  logic [7:0] char_second_o;
  logic [1:0] pair_count_o;
  logic       run_last_o;

  image_byte_t byte_q[$];
  hex_pair_t   pair_q[$];
  logic [7:0]  record_text[$];

  logic [7:0]  open_bytes[REC_BYTES];
  int unsigned open_fill = 0;
  logic [15:0] open_addr = 16'h0000;
  logic [15:0] next_segment = 16'h0000;
  logic        crlf_mode = 1'b0;
  string       hex_digits = "0123456789ABCDEF";

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_ticket = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned pairs_checked = 0;
  int unsigned images_queued = 0;
  int unsigned records_seen = 0;

  intel_hex_record_encoder #(
    .RECORD_BYTES(REC_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .image_end_i   (image_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_first_o  (char_first_o),
    .char_second_o (char_second_o),
    .pair_count_o  (pair_count_o),
    .run_last_o    (run_last_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic void put_hex(input logic [7:0] v);
    record_text.push_back(hex_digits[v[7:4]]);
    record_text.push_back(hex_digits[v[3:0]]);
  endfunction

  function automatic void emit_record(input int unsigned count, input logic [15:0] addr,
                                      input logic [7:0] rtype,
                                      input logic [7:0] data [REC_BYTES]);
    logic [7:0] sum;
    sum = count[7:0] + addr[15:8] + addr[7:0] + rtype;
    record_text.push_back(CHR_COLON);
    put_hex(count[7:0]);
    put_hex(addr[15:8]);
    put_hex(addr[7:0]);
    put_hex(rtype);
    for (int i = 0; i < count; i++) begin
      put_hex(data[i]);
      sum = sum + data[i];
    end
    put_hex(8'h00 - sum);
    if (crlf_mode) begin
      record_text.push_back(CHR_CR);
    end
    record_text.push_back(CHR_LF);
    records_seen++;
  endfunction

  function automatic void predict_hex_text(input logic [7:0] b, input logic fin);
    logic [7:0]  seg_bytes[REC_BYTES];
    logic        close_now;
    logic        two;
    int unsigned n;
    hex_pair_t   pair;
    record_text.delete();
    foreach (seg_bytes[i]) seg_bytes[i] = 8'h00;
    if (open_fill < REC_BYTES) begin
      open_bytes[open_fill] = b;
      open_fill++;
    end
    close_now = fin || open_fill >= REC_BYTES || (32'(open_addr) + open_fill >= 32'h10000);
    if (close_now) begin
      if (open_addr == 16'h0000) begin
        seg_bytes[0] = next_segment[15:8];
        seg_bytes[1] = next_segment[7:0];
        emit_record(2, 16'h0000, TYPE_SEG, seg_bytes);
        next_segment = next_segment + 16'd1;
      end
      emit_record(open_fill, open_addr, TYPE_DATA, open_bytes);
      open_addr = open_addr + open_fill[15:0];
      open_fill = 0;
    end
    if (fin) begin
      emit_record(0, 16'h0000, TYPE_EOF, open_bytes);
      open_addr = 16'h0000;
      next_segment = 16'h0000;
      open_fill = 0;
    end
    n = (record_text.size() + 1) / 2;
    for (int k = 0; k < n; k++) begin
      two = (2 * k + 1) < record_text.size();
      pair.first_chr = record_text[2 * k];
      pair.second_chr = two ? record_text[2 * k + 1] : 8'h00;
      pair.chars = two ? 2'd2 : 2'd1;
      pair.tail = (k == n - 1);
      pair_q.push_back(pair);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= 8'h00;
      image_end_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_hex_text(byte_q[0].data, byte_q[0].fin);
        void'(byte_q.pop_front());
        bytes_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          data_byte_i <= byte_q[0].data;
          image_end_i <= byte_q[0].fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : pair_monitor
    hex_pair_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pair_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction %02h %02h", char_first_o,
                                    char_second_o));
        end else begin
          want = pair_q.pop_front();
          pairs_checked++;
          if (char_first_o !== want.first_chr) begin
            report_mismatch($sformatf("char_first %02h, expected %02h", char_first_o,
                                      want.first_chr));
          end
          if (want.chars == 2'd2 && char_second_o !== want.second_chr) begin
            report_mismatch($sformatf("char_second %02h, expected %02h", char_second_o,
                                      want.second_chr));
          end
          if (pair_count_o !== want.chars) begin
            report_mismatch($sformatf("pair_count %0d, expected %0d", pair_count_o,
                                      want.chars));
          end
          if (run_last_o !== want.tail) begin
            report_mismatch($sformatf("run_last %0b, expected %0b", run_last_o, want.tail));
          end
        end
      end
      if (hold_served != hold_ticket) begin
        hold_served = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d transactions still expected", pair_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic fin);
    image_byte_t item;
    item.data = b;
    item.fin = fin;
    byte_q.push_back(item);
  endfunction

  task automatic write_crlf(input logic mode);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    crlf_mode = mode;
  endtask

  task automatic drain;
    while (byte_q.size() != 0 || pair_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random_images(input int unsigned target);
    int unsigned queued;
    int unsigned len;
    queued = 0;
    @(negedge clk_i);
    while (queued < target) begin
      case ($urandom_range(9))
        0: len = REC_BYTES;
        1: len = 2 * REC_BYTES;
        2: len = $urandom_range(REC_BYTES + 1, REC_BYTES - 1);
        3: len = $urandom_range(2 * REC_BYTES + 1, 2 * REC_BYTES - 1);
        default: len = $urandom_range(12, 1);
      endcase
      for (int i = 0; i < len; i++) begin
        push_byte(8'($urandom_range(255)), i == len - 1);
      end
      queued += len;
      images_queued++;
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic long_hold);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) begin
      hold_ticket++;
    end
    queue_random_images(35);
    drain();
  endtask

  initial begin
    foreach (open_bytes[i]) open_bytes[i] = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_crlf(1'b0);
    @(negedge clk_i);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    for (int i = 0; i < REC_BYTES; i++) begin
      push_byte(8'(i * 17), i == REC_BYTES - 1);
    end
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b1);
    images_queued += 4;
    drain();

    write_crlf(1'b1);
    run_phase(0, 0, 1'b1);
    write_crlf(1'b0);
    run_phase(58, 0, 1'b0);
    write_crlf(1'b1);
    run_phase(0, 58, 1'b0);
    write_crlf(1'b0);
    run_phase(10, 10, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pair_q.size() != 0) begin
      report_mismatch($sformatf("%0d transactions never arrived", pair_q.size()));
    end
    $display("Covered %0d bytes in %0d images, %0d records, %0d character pairs checked.",
             bytes_taken, images_queued, records_seen, pairs_checked);
    $display("Both line end modes, four idle patterns and a long output stall; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/ihex_pkg.sv
design/ihex_pack.sv
design/intel_hex_record_encoder.sv
tb/tb_intel_hex_record_encoder.sv
